// File: rtl/core/srbs_pkg.sv
// Shared widths, codes and control types of the selective-repeat bitmap scheduler.
package srbs_pkg;

    localparam int LEN_W      = 23;
    localparam int CMD_W      = 2;
    localparam int ACK_IDX_W  = 10;
    localparam int ACK_VAL_W  = 8;
    localparam int SEQ_OUT_W  = 12;
    localparam int SIZE_OUT_W = 11;
    localparam int OFF_W      = 23;

    localparam int MAP_WORD_W = 64;
    localparam int BIT_SEL_W  = $clog2(MAP_WORD_W);
    localparam int ACK_SHIFT  = $clog2(ACK_VAL_W);
    localparam int BYTE_SEL_W = $clog2(MAP_WORD_W / ACK_VAL_W);

    localparam int DEF_MAX_PACKETS   = 4096;
    localparam int DEF_PAYLOAD_BYTES = 1200;

    typedef enum logic [CMD_W-1:0] {
        CMD_MERGE   = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_START   = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CNT,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_HIT,
        ST_END
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear;
        logic div_step;
        logic cnt_load;
        logic mrg_rd;
        logic mrg_wr;
        logic scan_init;
        logic scan_step;
        logic load_hit;
        logic out_pkt;
        logic out_end;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic cur_ge_cnt;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/core/srbs_in_if.sv
// Input channel carrying one command beat with its acknowledgement payload.
interface srbs_in_if import srbs_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [ACK_IDX_W-1:0] ack_byte_index;
    logic [ACK_VAL_W-1:0] ack_byte_value;

    modport source (output valid, output cmd, output ack_byte_index, output ack_byte_value,
                    input ready);
    modport sink   (input valid, input cmd, input ack_byte_index, input ack_byte_value,
                    output ready);

endinterface

// File: rtl/core/srbs_out_if.sv
// Output channel carrying one scheduled-packet beat.
interface srbs_out_if import srbs_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [SEQ_OUT_W-1:0]  packet_seq;
    logic [SIZE_OUT_W-1:0] packet_size;
    logic [OFF_W-1:0]      byte_offset;
    logic                  round_end;

    modport source (output valid, output packet_seq, output packet_size, output byte_offset,
                    output round_end, input ready);
    modport sink   (input valid, input packet_seq, input packet_size, input byte_offset,
                    input round_end, output ready);

endinterface

// File: rtl/core/selective_retransmit_bitmap_scheduler_unit.sv
// Top level of the selective-repeat sender scheduler.
// Sender-side scheduler for a selective-repeat transfer. Each input beat is one command:
// start clears the acknowledgement bitmap and the round cursor, merge ORs one acknowledgement
// byte into the bitmap, and request returns the next unacknowledged packet (sequence, size,
// byte offset) or an end-of-round beat that rewinds the cursor. The packet count is
// recomputed from the length register on every merge and request by a reciprocal multiply,
// a back-multiply and one correction step. A request then scans the bitmap one 64-bit word
// at a time through the single read port of the bitmap memory. The bitmap words carry valid
// flags cleared at reset and on start, so no clearing pass is needed. A finished result
// waits in an output register while the next beat is accepted; a request whose result finds
// that register still occupied waits until it drains. The length register must be written
// only while the block is idle.
module selective_retransmit_bitmap_scheduler_unit import srbs_pkg::*; #(
    parameter int MAX_PACKETS   = DEF_MAX_PACKETS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    srbs_in_if.sink          i_req,
    srbs_out_if.source       o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    in_ready;

    srbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_cmd   (i_req.cmd),
        .o_in_ready (in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    srbs_dp #(
        .MAX_PACKETS   (MAX_PACKETS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_ack_idx     (i_req.ack_byte_index),
        .i_ack_val     (i_req.ack_byte_value),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_packet_seq  (o_rsp.packet_seq),
        .o_packet_size (o_rsp.packet_size),
        .o_byte_offset (o_rsp.byte_offset),
        .o_round_end   (o_rsp.round_end)
    );

    assign i_req.ready = in_ready;

endmodule

// File: rtl/core/srbs_ctrl.sv
// Controller state machine that sequences divide, merge and scan operations.
module srbs_ctrl import srbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    output logic             o_in_ready,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_is_req;
    logic   n_is_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_is_req <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_req <= n_is_req;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_req   = r_is_req;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_cmd)
                        CMD_MERGE: begin
                            n_is_req = 1'b0;
                            n_state  = ST_DIV;
                        end
                        CMD_REQUEST: begin
                            n_is_req = 1'b1;
                            n_state  = ST_DIV;
                        end
                        CMD_START: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                o_cmd.cnt_load = 1'b1;
                n_state = r_is_req ? ST_SCAN_INIT : ST_MRG_RD;
            end
            ST_MRG_RD: begin
                o_cmd.mrg_rd = 1'b1;
                n_state = ST_MRG_WR;
            end
            ST_MRG_WR: begin
                o_cmd.mrg_wr = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCAN_INIT: begin
                if (i_sts.cur_ge_cnt) begin
                    n_state = ST_END;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    o_cmd.load_hit = 1'b1;
                    n_state = ST_HIT;
                end else if (i_sts.scan_last) begin
                    n_state = ST_END;
                end
            end
            ST_HIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_pkt = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_end = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/srbs_dp.sv
// Datapath with the length divider, acknowledgement bitmap memory, scanner and result register.
module srbs_dp import srbs_pkg::*; #(
    parameter int MAX_PACKETS   = DEF_MAX_PACKETS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [LEN_W-1:0]      i_cfg_wdata,
    input  logic [ACK_IDX_W-1:0]  i_ack_idx,
    input  logic [ACK_VAL_W-1:0]  i_ack_val,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [SEQ_OUT_W-1:0]  o_packet_seq,
    output logic [SIZE_OUT_W-1:0] o_packet_size,
    output logic [OFF_W-1:0]      o_byte_offset,
    output logic                  o_round_end
);

    localparam int WORDS   = (MAX_PACKETS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SEQ_W   = $clog2(MAX_PACKETS + 1);
    localparam int CNT_W   = (SEQ_W > BIT_SEL_W) ? SEQ_W : BIT_SEL_W + 1;
    localparam int P_W     = $clog2(PAYLOAD_BYTES + 1);
    localparam int DCNT_W  = 2;
    localparam int SUM_W   = LEN_W + 1;
    localparam int ABIT_W  = ACK_IDX_W + ACK_SHIFT;
    localparam int MI_W    = ((ABIT_W > CNT_W) ? ABIT_W : CNT_W) + 1;
    localparam int FND_W   = WORD_AW + BIT_SEL_W;
    localparam int PROD_W  = FND_W + P_W;
    localparam int RECIP_W = $clog2((1 << LEN_W) / PAYLOAD_BYTES + 1);
    localparam int RPROD_W = LEN_W + RECIP_W;
    localparam int BACK_W  = LEN_W + P_W;
    localparam logic [RECIP_W-1:0]    RECIP    = RECIP_W'((1 << LEN_W) / PAYLOAD_BYTES);
    localparam logic [DCNT_W-1:0]     DIV_EST  = 2'd2;
    localparam logic [DCNT_W-1:0]     DIV_BACK = 2'd1;
    localparam logic [MAP_WORD_W-1:0] ALL1     = '1;

    logic [LEN_W-1:0]      r_len;
    logic [ACK_IDX_W-1:0]  r_ack_idx;
    logic [ACK_VAL_W-1:0]  r_ack_val;
    logic [LEN_W-1:0]      r_div_x;
    logic [LEN_W-1:0]      r_div_q;
    logic [P_W-1:0]        r_div_rem;
    logic [DCNT_W-1:0]     r_div_cnt;
    logic [CNT_W-1:0]      r_count;
    logic [P_W-1:0]        r_last_size;
    logic [WORD_AW-1:0]    r_last_word;
    logic [CNT_W-1:0]      r_cursor;
    logic [WORD_AW-1:0]    r_scan_addr;
    logic [WORD_AW-1:0]    r_chk_word;
    logic [MAP_WORD_W-1:0] r_rdata;
    logic                  r_rd_vld;
    logic [WORDS-1:0]      r_word_vld;
    logic [FND_W-1:0]      r_found;
    logic                  r_out_valid;
    logic [SEQ_OUT_W-1:0]  r_out_seq;
    logic [SIZE_OUT_W-1:0] r_out_size;
    logic [OFF_W-1:0]      r_out_off;
    logic                  r_out_end;
    logic [MAP_WORD_W-1:0] r_map_mem [WORDS];

    logic [RPROD_W-1:0]    div_recip;
    logic [RECIP_W-1:0]    div_qest;
    logic [BACK_W-1:0]     div_back;
    logic                  div_ge;
    logic [SUM_W-1:0]      cnt_sum;
    logic                  cnt_sat;
    logic [CNT_W-1:0]      cnt_val;
    logic [CNT_W-1:0]      cnt_val_m1;
    logic [P_W-1:0]        last_val;
    logic [CNT_W-1:0]      cnt_m1;
    logic [WORD_AW-1:0]    cur_word;
    logic [WORD_AW-1:0]    mrg_word;
    logic [WORD_AW-1:0]    rd_addr;
    logic [MAP_WORD_W-1:0] chk_data;
    logic [MAP_WORD_W-1:0] lo_mask;
    logic [MAP_WORD_W-1:0] hi_mask;
    logic [MAP_WORD_W-1:0] free;
    logic [MAP_WORD_W-1:0] lowest;
    logic [BIT_SEL_W-1:0]  enc;
    logic [ACK_VAL_W-1:0]  mrg_bits;
    logic [MAP_WORD_W-1:0] mrg_data;
    logic [PROD_W-1:0]     prod;
    logic                  is_last;

    // The reciprocal estimate is at most one below the true quotient.
    assign div_recip = RPROD_W'(r_div_x) * RPROD_W'(RECIP);
    assign div_qest  = div_recip[RPROD_W-1:LEN_W];
    assign div_back  = BACK_W'(r_div_q) * BACK_W'(PAYLOAD_BYTES);
    assign div_ge    = r_div_x >= LEN_W'(PAYLOAD_BYTES);

    assign cnt_sum    = SUM_W'(r_div_q) + SUM_W'(r_div_rem != '0);
    assign cnt_sat    = cnt_sum > SUM_W'(MAX_PACKETS);
    assign cnt_val    = cnt_sat ? CNT_W'(MAX_PACKETS) : CNT_W'(cnt_sum);
    assign cnt_val_m1 = cnt_val - CNT_W'(1);
    assign last_val   = (cnt_sat || r_div_rem == '0) ? P_W'(PAYLOAD_BYTES) : r_div_rem;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign cur_word = WORD_AW'(r_cursor >> BIT_SEL_W);
    assign mrg_word = WORD_AW'(r_ack_idx >> BYTE_SEL_W);

    always_comb begin
        if (i_cmd.scan_init) begin
            rd_addr = cur_word;
        end else if (i_cmd.mrg_rd) begin
            rd_addr = mrg_word;
        end else begin
            rd_addr = r_scan_addr;
        end
    end

    assign chk_data = r_rd_vld ? r_rdata : '0;
    assign lo_mask  = (r_chk_word == cur_word) ? ALL1 << r_cursor[BIT_SEL_W-1:0] : ALL1;
    assign hi_mask  = (r_chk_word == r_last_word)
                    ? ALL1 >> (BIT_SEL_W'(MAP_WORD_W - 1) - cnt_m1[BIT_SEL_W-1:0]) : ALL1;
    assign free     = ~chk_data & lo_mask & hi_mask;
    assign lowest   = free & (~free + MAP_WORD_W'(1));

    always_comb begin
        enc = '0;
        for (int j = 0; j < MAP_WORD_W; j++) begin
            enc = enc | (lowest[j] ? BIT_SEL_W'(j) : BIT_SEL_W'(0));
        end
    end

    always_comb begin
        for (int b = 0; b < ACK_VAL_W; b++) begin
            mrg_bits[b] = r_ack_val[b]
                        && (((MI_W'(r_ack_idx) << ACK_SHIFT) + MI_W'(b)) < MI_W'(r_count));
        end
    end

    assign mrg_data = chk_data | (MAP_WORD_W'(mrg_bits)
                    << (BIT_SEL_W'(r_ack_idx[BYTE_SEL_W-1:0]) << ACK_SHIFT));

    assign prod    = PROD_W'(r_found) * PROD_W'(PAYLOAD_BYTES);
    assign is_last = CNT_W'(r_found) == cnt_m1;

    assign o_sts.div_last   = r_div_cnt == '0;
    assign o_sts.cur_ge_cnt = r_cursor >= r_count;
    assign o_sts.scan_hit   = |free;
    assign o_sts.scan_last  = r_chk_word == r_last_word;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_cursor    <= '0;
            r_word_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (i_cmd.clear || i_cmd.out_end) begin
                r_cursor <= '0;
            end else if (i_cmd.out_pkt) begin
                r_cursor <= CNT_W'(r_found) + CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_word_vld <= '0;
            end else if (i_cmd.mrg_wr && (|mrg_bits)) begin
                r_word_vld[mrg_word] <= 1'b1;
            end
            if (i_cmd.out_pkt || i_cmd.out_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ack_idx <= i_ack_idx;
            r_ack_val <= i_ack_val;
            r_div_x   <= r_len;
            r_div_cnt <= DIV_EST;
        end else if (i_cmd.div_step) begin
            case (r_div_cnt)
                DIV_EST: begin
                    r_div_q <= LEN_W'(div_qest);
                end
                DIV_BACK: begin
                    r_div_x <= r_div_x - LEN_W'(div_back);
                end
                default: begin
                    if (div_ge) begin
                        r_div_q   <= r_div_q + LEN_W'(1);
                        r_div_rem <= P_W'(r_div_x - LEN_W'(PAYLOAD_BYTES));
                    end else begin
                        r_div_rem <= P_W'(r_div_x);
                    end
                end
            endcase
            r_div_cnt <= r_div_cnt - DCNT_W'(1);
        end
        if (i_cmd.cnt_load) begin
            r_count     <= cnt_val;
            r_last_size <= last_val;
            r_last_word <= WORD_AW'(cnt_val_m1 >> BIT_SEL_W);
        end
        if (i_cmd.scan_init) begin
            r_scan_addr <= cur_word + WORD_AW'(1);
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr + WORD_AW'(1);
        end
        if (i_cmd.load_hit) begin
            r_found <= {r_chk_word, enc};
        end
        if (i_cmd.out_pkt) begin
            r_out_seq  <= SEQ_OUT_W'(r_found);
            r_out_size <= SIZE_OUT_W'(is_last ? r_last_size : P_W'(PAYLOAD_BYTES));
            r_out_off  <= OFF_W'(prod);
            r_out_end  <= 1'b0;
        end else if (i_cmd.out_end) begin
            r_out_seq  <= '0;
            r_out_size <= '0;
            r_out_off  <= '0;
            r_out_end  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mrg_wr && (|mrg_bits)) begin
            r_map_mem[mrg_word] <= mrg_data;
        end
        r_rdata    <= r_map_mem[rd_addr];
        r_rd_vld   <= r_word_vld[rd_addr];
        r_chk_word <= rd_addr;
    end

    assign o_out_valid   = r_out_valid;
    assign o_packet_seq  = r_out_seq;
    assign o_packet_size = r_out_size;
    assign o_byte_offset = r_out_off;
    assign o_round_end   = r_out_end;

endmodule

// File: rtl/core/srbs_chk.sv
// Port-level assertion checker for the scheduler, bound to the top level.
module srbs_chk import srbs_pkg::*; #(
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic [CMD_W-1:0]      i_req_cmd,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [SEQ_OUT_W-1:0]  i_rsp_seq,
    input logic [SIZE_OUT_W-1:0] i_rsp_size,
    input logic [OFF_W-1:0]      i_rsp_off,
    input logic                  i_rsp_end
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_seq)
            && $stable(i_rsp_size) && $stable(i_rsp_off) && $stable(i_rsp_end))
        else $error("Stalled result beat changed.");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_end |-> i_rsp_seq == '0 && i_rsp_size == '0 && i_rsp_off == '0)
        else $error("End-of-round beat carries nonzero packet fields.");

    a_size_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_end |-> 32'(i_rsp_size) <= PAYLOAD_BYTES)
        else $error("Packet size exceeds the payload size.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_cmd == CMD_MERGE || i_req_cmd == CMD_REQUEST)
            |=> !i_req_ready)
        else $error("Merge or request beat did not occupy the block.");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("Result beat offered right after reset.");

endmodule

bind selective_retransmit_bitmap_scheduler_unit srbs_chk #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_srbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_cmd   (i_req.cmd),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_seq   (o_rsp.packet_seq),
    .i_rsp_size  (o_rsp.packet_size),
    .i_rsp_off   (o_rsp.byte_offset),
    .i_rsp_end   (o_rsp.round_end)
);

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the selective-repeat scheduler: directed table, then random phases.
module testbench;
    import srbs_pkg::*;

    localparam int MAX_PKTS      = DEF_MAX_PACKETS;
    localparam int PAYLOAD       = DEF_PAYLOAD_BYTES;
    localparam int MAP_BYTES     = MAX_PKTS / ACK_VAL_W;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = 120;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PLAN_ROWS     = 27;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam logic [LEN_W-1:0] FULL_LENGTH = LEN_W'(MAX_PKTS * PAYLOAD);
    localparam logic [LEN_W-1:0] LENGTH_TOP  = '1;

    typedef struct packed {
        logic [SEQ_OUT_W-1:0]  seq;
        logic [SIZE_OUT_W-1:0] size;
        logic [OFF_W-1:0]      offset;
        logic                  round_end;
    } t_sched_beat;

    typedef struct packed {
        logic                 is_cfg;
        logic [LEN_W-1:0]     length;
        logic [CMD_W-1:0]     cmd;
        logic [ACK_IDX_W-1:0] idx;
        logic [ACK_VAL_W-1:0] val;
        logic                 typed;
        t_sched_beat          want;
    } t_plan_row;

    localparam t_sched_beat NO_BEAT  = '0;
    localparam t_sched_beat END_BEAT = '{12'd0, 11'd0, 23'd0, 1'b1};

    t_plan_row plan [PLAN_ROWS] = '{
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, END_BEAT},
        '{1'b1, 23'd2500, CMD_MERGE, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd0, 11'd1200, 23'd0, 1'b0}},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd1, 11'd1200, 23'd1200, 1'b0}},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd2, 11'd100, 23'd2400, 1'b0}},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, END_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd0, 8'hFD, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd1, 11'd1200, 23'd1200, 1'b0}},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, END_BEAT},
        '{1'b0, 23'd0, CMD_UNUSED, 10'd0, 8'h02, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd1, 11'd1200, 23'd1200, 1'b0}},
        '{1'b0, 23'd0, CMD_START, 10'd1023, 8'hFF, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd0, 11'd1200, 23'd0, 1'b0}},
        '{1'b1, 23'd0, CMD_MERGE, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, END_BEAT},
        '{1'b1, 23'd3600, CMD_MERGE, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd0, 8'h03, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b1, '{12'd2, 11'd1200, 23'd2400, 1'b0}},
        '{1'b1, 23'd4915200, CMD_MERGE, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd512, 8'hFF, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd1023, 8'hFF, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd511, 8'h7F, 1'b0, NO_BEAT},
        '{1'b1, 23'd8388607, CMD_MERGE, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_MERGE, 10'd1, 8'hAA, 1'b0, NO_BEAT},
        '{1'b0, 23'd0, CMD_REQUEST, 10'd0, 8'h00, 1'b0, NO_BEAT}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [LEN_W-1:0] i_cfg_wdata;

    srbs_in_if  req_if ();
    srbs_out_if rsp_if ();

    selective_retransmit_bitmap_scheduler_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    bit               ack_seen [MAX_PKTS];
    int unsigned      cursor;
    logic [LEN_W-1:0] length_reg;
    t_sched_beat      pending_beats [$];
    int unsigned      mismatches   = 0;
    int unsigned      beats_sent   = 0;
    int unsigned      quiet_cycles = 0;
    bit               no_idle      = 1'b0;

    function automatic int unsigned packet_total();
        int unsigned n;
        n = (int'(length_reg) + PAYLOAD - 1) / PAYLOAD;
        return (n > MAX_PKTS) ? MAX_PKTS : n;
    endfunction

    function automatic int unsigned tail_size(input int unsigned total);
        int unsigned full_bytes;
        if (total == 0) return 0;
        full_bytes = (total - 1) * PAYLOAD;
        if (length_reg <= full_bytes || length_reg - full_bytes > PAYLOAD) return PAYLOAD;
        return length_reg - full_bytes;
    endfunction

    function automatic bit advance_scheduler(input logic [CMD_W-1:0] cmd,
                                             input logic [ACK_IDX_W-1:0] idx,
                                             input logic [ACK_VAL_W-1:0] val,
                                             output t_sched_beat beat);
        int unsigned total;
        int unsigned seq;
        total = packet_total();
        beat = '0;
        case (cmd)
            CMD_MERGE: begin
                for (int b = 0; b < ACK_VAL_W; b++) begin
                    seq = idx * ACK_VAL_W + b;
                    if (val[b] && seq < total) ack_seen[seq] = 1'b1;
                end
                return 1'b0;
            end
            CMD_START: begin
                foreach (ack_seen[k]) ack_seen[k] = 1'b0;
                cursor = 0;
                return 1'b0;
            end
            CMD_REQUEST: begin
                seq = cursor;
                while (seq < total && ack_seen[seq]) seq++;
                if (seq < total) begin
                    beat.seq    = SEQ_OUT_W'(seq);
                    beat.size   = SIZE_OUT_W'((seq == total - 1) ? tail_size(total) : PAYLOAD);
                    beat.offset = OFF_W'(seq * PAYLOAD);
                    cursor      = seq + 1;
                end else begin
                    beat.round_end = 1'b1;
                    cursor         = 0;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ACK_IDX_W-1:0] idx,
                             input logic [ACK_VAL_W-1:0] val, input bit typed,
                             input t_sched_beat want);
        int unsigned gap;
        t_sched_beat beat;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid          <= 1'b1;
        req_if.cmd            <= cmd;
        req_if.ack_byte_index <= idx;
        req_if.ack_byte_value <= val;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
        if (advance_scheduler(cmd, idx, val, beat)) pending_beats.push_back(typed ? want : beat);
        if (cmd != CMD_UNUSED) beats_sent++;
    endtask

    task automatic send_request();
        send_beat(CMD_REQUEST, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom), 1'b0, NO_BEAT);
    endtask

    task automatic drain_results(input int unsigned extra);
        req_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        length_reg = value;
    endtask

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        t_sched_beat want;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_if.valid !== 1'b1) @(posedge i_clk);
            if (pending_beats.size() == 0) begin
                $error("result beat arrived with no request waiting");
                mismatches++;
            end else begin
                want = pending_beats.pop_front();
                check_field("packet_seq", want.seq, rsp_if.packet_seq);
                check_field("packet_size", want.size, rsp_if.packet_size);
                check_field("byte_offset", want.offset, rsp_if.byte_offset);
                check_field("round_end", want.round_end, rsp_if.round_end);
            end
        end
    end

    initial begin : stimulus
        int unsigned      phase;
        int unsigned      pick;
        int unsigned      top_idx;
        logic [LEN_W-1:0] len_pick;
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        req_if.valid          <= 1'b0;
        req_if.cmd            <= CMD_MERGE;
        req_if.ack_byte_index <= '0;
        req_if.ack_byte_value <= '0;
        cursor     = 0;
        length_reg = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                drain_results(SETTLE_CYCLES);
                write_length(plan[r].length);
            end else begin
                send_beat(plan[r].cmd, plan[r].idx, plan[r].val, plan[r].typed, plan[r].want);
            end
        end

        beats_sent = 0;
        phase      = 0;
        while (beats_sent < RANDOM_ITEMS) begin
            drain_results(SETTLE_CYCLES);
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // Acknowledge nearly the whole bitmap so that the top sequence numbers are reached.
                write_length(FULL_LENGTH);
                send_beat(CMD_START, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom), 1'b0, NO_BEAT);
                for (int k = 0; k < MAP_BYTES; k++) begin
                    send_beat(CMD_MERGE, ACK_IDX_W'(k),
                              (k == 0 || k == MAP_BYTES - 1) ? ACK_VAL_W'($urandom) : 8'hFF,
                              1'b0, NO_BEAT);
                end
                repeat (12) send_request();
                drain_results(SETTLE_CYCLES);
                write_length(LENGTH_TOP);
                repeat (6) send_request();
                drain_results(SETTLE_CYCLES);
                write_length(FULL_LENGTH - LEN_W'($urandom_range(1, PAYLOAD - 1)));
                repeat (6) send_request();
            end else begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       len_pick = '0;
                    1:       len_pick = LEN_W'(PAYLOAD * $urandom_range(1, 40));
                    2:       len_pick = LEN_W'($urandom_range(int'(FULL_LENGTH) + 1,
                                                              int'(LENGTH_TOP)));
                    default: len_pick = LEN_W'($urandom_range(1, 40 * PAYLOAD));
                endcase
                write_length(len_pick);
                top_idx = (packet_total() == 0) ? 0 : (packet_total() - 1) / ACK_VAL_W;
                if ($urandom_range(0, 1) == 1) begin
                    send_beat(CMD_START, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom), 1'b0,
                              NO_BEAT);
                end
                repeat ($urandom_range(10, 40)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        send_request();
                    end else if (pick < 85) begin
                        send_beat(CMD_MERGE, ACK_IDX_W'($urandom_range(0, top_idx)),
                                  ($urandom_range(0, 3) == 0) ? 8'hFF : ACK_VAL_W'($urandom),
                                  1'b0, NO_BEAT);
                    end else if (pick < 90) begin
                        send_beat(CMD_MERGE, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom),
                                  1'b0, NO_BEAT);
                    end else if (pick < 94) begin
                        send_beat(CMD_UNUSED, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom),
                                  1'b0, NO_BEAT);
                    end else begin
                        send_beat(CMD_START, ACK_IDX_W'($urandom), ACK_VAL_W'($urandom),
                                  1'b0, NO_BEAT);
                    end
                end
            end
            phase++;
        end

        drain_results(SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
